// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the slot table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define GST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/gst_pkg.sv =====
// ----------------------------------------------------------------------------
// gst_pkg
// Types and constants shared by the generational slot table.
// ----------------------------------------------------------------------------
package gst_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int GEN_W          = 32;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;

	// Result of the shared generation unit.
	typedef struct packed {
		logic             eq;
		logic [GEN_W-1:0] next;
	} gen_res_t;

endpackage

// ===== rtl/gst_ram.sv =====
// ----------------------------------------------------------------------------
// gst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gst_gen_unit.sv =====
// ----------------------------------------------------------------------------
// gst_gen_unit
// Shared generation unit: compare against a handle, advance with wrap to one.
// ----------------------------------------------------------------------------
module gst_gen_unit (
	input  logic [gst_pkg::GEN_W-1:0] cur,
	input  logic [gst_pkg::GEN_W-1:0] handle,
	output gst_pkg::gen_res_t         res
);

	logic [gst_pkg::GEN_W-1:0] inc;

	assign inc = cur + gst_pkg::GEN_W'(1);

	always_comb begin
		res.eq   = (cur == handle);
		// skip zero on wrap: zero never names a live generation
		res.next = (inc == '0) ? gst_pkg::GEN_W'(1) : inc;
	end

endmodule

// ===== rtl/generational_handle_slot_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_slot_table
// Slot table with per-slot alive marks and 32-bit generations.
// Request words (req_valid/req_ready) carry opcode, handle_slot and
// handle_generation; each returns one response word (rsp_valid/rsp_ready)
// with status, granted_slot, granted_generation and high_water.
// A small sequencer serves one request at a time; req_ready is high only
// while it is idle. Allocate scans the alive marks from slot zero, one
// alive mark per cycle, for the lowest free slot (or to the end when the
// table is full); release and check read the generation RAM, then use
// the shared compare unit, skipping both when the slot is out of range;
// clear drops the marks directly. rsp_valid rises together with req_ready.
// Reset clears the alive marks, the generation valid bits, the high-water
// count and the sequencer; no clearing pass runs.
// On a receiver stall, hold the finished word until the output register
// frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module generational_handle_slot_table #(
	parameter int SLOT_COUNT = gst_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  handle_slot,
	input  logic [31:0] handle_generation,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [3:0]  granted_slot,
	output logic [31:0] granted_generation,
	output logic [4:0]  high_water
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [8:0]    SLOT_LIMIT = 9'(SLOT_COUNT);
	localparam logic [CW-1:0] SLOT_END   = CW'(SLOT_COUNT);

	gst_pkg::state_t state_q, state_d;

	// request hold
	gst_pkg::op_t              op_q;
	logic [7:0]                slot_q;
	logic [gst_pkg::GEN_W-1:0] hgen_q;

	// table state
	logic [SLOT_COUNT-1:0] alive_q;
	logic [SLOT_COUNT-1:0] gvalid_q;
	logic [CW-1:0]         highest_q;
	logic [CW-1:0]         idx_q;

	// finished result, then output register
	gst_pkg::status_t          res_status_q;
	logic [3:0]                res_slot_q;
	logic [gst_pkg::GEN_W-1:0] res_gen_q;
	logic                      rsp_valid_q;
	logic [1:0]                rsp_status_q;
	logic [3:0]                rsp_slot_q;
	logic [gst_pkg::GEN_W-1:0] rsp_gen_q;
	logic [4:0]                rsp_hw_q;

	logic                      accept;
	logic                      in_range;
	logic                      scan_end;
	logic                      scan_free;
	logic                      out_free;
	logic [SW-1:0]             rd_addr;
	logic [SW-1:0]             slot_a;
	logic                      ram_we;
	logic [gst_pkg::GEN_W-1:0] ram_rdata;
	logic [gst_pkg::GEN_W-1:0] cur_gen;
	logic                      handle_ok;
	gst_pkg::gen_res_t         unit_res;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == gst_pkg::S_IDLE);
	assign in_range  = ({1'b0, slot_q} < SLOT_LIMIT);
	assign scan_end  = (idx_q == SLOT_END);
	// only look at the alive mark once the index is known to be in range
	assign scan_free = !scan_end && !alive_q[idx_q[SW-1:0]];
	assign out_free  = !rsp_valid_q || rsp_ready;

	// scan reads at the walking index, release/check at the handle slot
	assign rd_addr = (state_q == gst_pkg::S_SCAN) ? idx_q[SW-1:0] : slot_q[SW-1:0];
	assign slot_a  = (op_q == gst_pkg::OP_ALLOC) ? idx_q[SW-1:0] : slot_q[SW-1:0];
	assign ram_we  = (state_q == gst_pkg::S_EVAL) && (op_q == gst_pkg::OP_ALLOC);

	gst_ram #(
		.WIDTH (gst_pkg::GEN_W),
		.DEPTH (SLOT_COUNT)
	) u_gen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_a),
		.wdata (unit_res.next),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// an entry never written since clear reads as generation zero
	assign cur_gen = gvalid_q[slot_a] ? ram_rdata : '0;

	gst_gen_unit u_gen_unit (
		.cur    (cur_gen),
		.handle (hgen_q),
		.res    (unit_res)
	);

	assign handle_ok = alive_q[slot_a] && unit_res.eq;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gst_pkg::S_IDLE: begin
				if (accept) begin
					case (gst_pkg::op_t'(opcode))
						gst_pkg::OP_ALLOC: state_d = gst_pkg::S_SCAN;
						gst_pkg::OP_CLEAR: state_d = gst_pkg::S_EVAL;
						default:           state_d = gst_pkg::S_READ;
					endcase
				end
			end
			gst_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = gst_pkg::S_DONE;
				end else if (scan_free) begin
					state_d = gst_pkg::S_EVAL;
				end
			end
			gst_pkg::S_READ: begin
				state_d = in_range ? gst_pkg::S_EVAL : gst_pkg::S_DONE;
			end
			gst_pkg::S_EVAL: begin
				state_d = gst_pkg::S_DONE;
			end
			gst_pkg::S_DONE: begin
				if (out_free) begin
					state_d = gst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gst_pkg::S_IDLE;
			end
		endcase
	end

	// request hold: payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= gst_pkg::op_t'(opcode);
			slot_q <= handle_slot;
			hgen_q <= handle_generation;
		end
	end

	// table state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q      <= '0;
			gvalid_q     <= '0;
			highest_q    <= '0;
			idx_q        <= '0;
			res_status_q <= gst_pkg::ST_OK;
			res_slot_q   <= '0;
			res_gen_q    <= '0;
		end else begin
			case (state_q)
				gst_pkg::S_IDLE: begin
					idx_q <= '0;
				end
				gst_pkg::S_SCAN: begin
					if (scan_end) begin
						res_status_q <= gst_pkg::ST_EXHAUSTED;
						res_slot_q   <= '0;
						res_gen_q    <= '0;
					end else if (!scan_free) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				gst_pkg::S_READ: begin
					if (!in_range) begin
						res_status_q <= gst_pkg::ST_INVALID;
						res_slot_q   <= '0;
						res_gen_q    <= '0;
					end
				end
				gst_pkg::S_EVAL: begin
					res_slot_q   <= '0;
					res_gen_q    <= '0;
					res_status_q <= gst_pkg::ST_OK;
					case (op_q)
						gst_pkg::OP_ALLOC: begin
							alive_q[slot_a]  <= 1'b1;
							gvalid_q[slot_a] <= 1'b1;
							if (idx_q >= highest_q) begin
								highest_q <= idx_q + CW'(1);
							end
							res_slot_q <= 4'(idx_q);
							res_gen_q  <= unit_res.next;
						end
						gst_pkg::OP_RELEASE: begin
							if (handle_ok) begin
								alive_q[slot_a] <= 1'b0;
							end else begin
								res_status_q <= gst_pkg::ST_INVALID;
							end
						end
						gst_pkg::OP_CHECK: begin
							if (!handle_ok) begin
								res_status_q <= gst_pkg::ST_INVALID;
							end
						end
						default: begin
							// clear: drop every mark and count
							alive_q   <= '0;
							gvalid_q  <= '0;
							highest_q <= '0;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == gst_pkg::S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gst_pkg::S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= res_slot_q;
			rsp_gen_q    <= res_gen_q;
			rsp_hw_q     <= 5'(highest_q);
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign status             = rsp_status_q;
	assign granted_slot       = rsp_slot_q;
	assign granted_generation = rsp_gen_q;
	assign high_water         = rsp_hw_q;

	// an accepted word leaves the sequencer busy in the next cycle
	`GST_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !req_ready)
	// a granted generation is never zero
	`GST_ASSERT_IMP(a_gen_nonzero, clk, arst_n, ram_we, unit_res.next != '0)
	// the high-water count stays within the table
	`GST_ASSERT_IMP(a_hw_bound, clk, arst_n, 1'b1, highest_q <= SLOT_END)
	// a live slot always has a written generation
	`GST_ASSERT_IMP(a_alive_written, clk, arst_n, 1'b1, $countones(alive_q & ~gvalid_q) == 0)

endmodule
